FILE: hdl/crlf_pkg.sv
// ----------------------------------------------------------------------------
// crlf_pkg
// shared types and constants for the crlf line receiver
// ----------------------------------------------------------------------------
package crlf_pkg;

  localparam int unsigned BufDepthDef = 64;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef enum logic {
    OP_RX   = 1'b0,
    OP_POLL = 1'b1
  } op_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } back_state_e;

  // classified command passed from front to back
  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       is_cr;
    logic       is_lf;
  } cmd_t;

endpackage

FILE: hdl/crlf_ram.sv
// ----------------------------------------------------------------------------
// crlf_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module crlf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/crlf_front.sv
// ----------------------------------------------------------------------------
// crlf_front
// accepts input beats, classifies the byte and queues the command
// ----------------------------------------------------------------------------
module crlf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          operation_i,
  input  logic [7:0]    rx_byte_i,
  output logic          cmd_valid_o,
  input  logic          cmd_pop_i,
  output crlf_pkg::cmd_t cmd_o
);
  import crlf_pkg::*;

  localparam int unsigned QW = $clog2(QueueDepth);

  cmd_t          queue_q [QueueDepth];
  logic [QW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QW:0]   count_q, count_d;
  logic          push, pop;
  cmd_t          cmd_in;

  assign in_ready_o  = (count_q != (QW+1)'(QueueDepth));
  assign cmd_valid_o = (count_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    cmd_in.op    = op_e'(operation_i);
    cmd_in.data  = rx_byte_i;
    cmd_in.is_cr = (rx_byte_i == CHAR_CR);
    cmd_in.is_lf = (rx_byte_i == CHAR_LF);
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + (QW+1)'(1);
    end else if (pop && !push) begin
      count_d = count_q - (QW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

FILE: hdl/crlf_back.sv
// ----------------------------------------------------------------------------
// crlf_back
// executes queued commands: line assembly, framing and line drain
// ----------------------------------------------------------------------------
module crlf_back #(
  parameter int unsigned BUF_DEPTH = crlf_pkg::BufDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_pop_o,
  input  crlf_pkg::cmd_t cmd_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           last_byte_o
);
  import crlf_pkg::*;

  localparam int unsigned AW = $clog2(BUF_DEPTH);

  back_state_e   state_q, state_d;
  logic [AW-1:0] fill_q, fill_d;
  logic          cr_q, cr_d;
  logic          rdy_q, rdy_d;
  logic [AW-1:0] len_q, len_d;
  logic [AW-1:0] idx_q, idx_d;
  logic          rd_pend_q, rd_pend_d;
  logic          rd_last_q, rd_last_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q, out_byte_d;
  logic          out_last_q, out_last_d;

  logic          out_free, issue, move, drain_done, start_drain;
  logic          ram_we;
  logic [7:0]    ram_rdata;
  logic [AW:0]   fill_next;

  assign out_free    = !out_valid_q || out_ready_i;
  assign issue       = (state_q == ST_DRAIN) && (idx_q != len_q) && (!rd_pend_q || out_free);
  assign move        = rd_pend_q && out_free;
  assign drain_done  = (idx_q == len_q) && (!rd_pend_q || move);
  assign cmd_pop_o   = (state_q == ST_IDLE) && cmd_valid_i;
  assign start_drain = cmd_pop_o && (cmd_i.op == OP_POLL) && rdy_q && (fill_q != '0);
  assign fill_next   = {1'b0, fill_q} + (AW+1)'(1);
  assign ram_we      = cmd_pop_o && (cmd_i.op == OP_RX) && !rdy_q && !cr_q && !cmd_i.is_cr;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_drain) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    fill_d      = fill_q;
    cr_d        = cr_q;
    rdy_d       = rdy_q;
    len_d       = len_q;
    idx_d       = idx_q;
    rd_pend_d   = rd_pend_q;
    rd_last_d   = rd_last_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (move) begin
      out_valid_d = 1'b1;
      out_byte_d  = ram_rdata;
      out_last_d  = rd_last_q;
      rd_pend_d   = 1'b0;
    end
    if (issue) begin
      rd_pend_d = 1'b1;
      rd_last_d = ((idx_q + AW'(1)) == len_q);
      idx_d     = idx_q + AW'(1);
    end

    case (state_q)
      ST_IDLE: begin
        if (cmd_pop_o) begin
          if (cmd_i.op == OP_POLL) begin
            if (rdy_q) begin
              len_d  = fill_q;
              idx_d  = '0;
              fill_d = '0;
              cr_d   = 1'b0;
              rdy_d  = 1'b0;
            end
          end else if (!rdy_q) begin
            if (cr_q) begin
              if (cmd_i.is_lf) begin
                rdy_d = 1'b1;
              end else begin
                fill_d = '0;
                cr_d   = 1'b0;
              end
            end else if (cmd_i.is_cr) begin
              cr_d = 1'b1;
            end else if (fill_next >= (AW+1)'(BUF_DEPTH)) begin
              fill_d = '0;
            end else begin
              fill_d = fill_next[AW-1:0];
            end
          end
        end
      end
      ST_DRAIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      cr_q        <= 1'b0;
      rdy_q       <= 1'b0;
      len_q       <= '0;
      idx_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      cr_q        <= cr_d;
      rdy_q       <= rdy_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_last_q  <= rd_last_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  crlf_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q),
    .wdata_i (cmd_i.data),
    .re_i    (issue),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_byte_o = out_last_q;

endmodule

FILE: hdl/crlf_line_receiver.sv
// ----------------------------------------------------------------------------
// crlf_line_receiver
// assembles a received byte stream into cr lf terminated lines
// ----------------------------------------------------------------------------
// Input beats enter a two-entry command queue, so up to two further beats are
// still taken while a line is being forwarded. Received bytes are executed one
// per cycle while no line is being forwarded. A poll of a ready line occupies
// the executing side until the line is out and forwards one byte per cycle
// when the output is not stalled, the rate being set by the single read port
// of the line store; meanwhile queued commands wait. A line over BUF_DEPTH-1
// bytes restarts the store; bytes received while a line is ready are dropped.
module crlf_line_receiver #(
  parameter int unsigned BUF_DEPTH = crlf_pkg::BufDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       operation_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_byte_o
);
  import crlf_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_pop;

  crlf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .rx_byte_i   (rx_byte_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  crlf_back #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule

FILE: hdl/crlf_checker.sv
// ----------------------------------------------------------------------------
// crlf_checker
// port level checks of the crlf line receiver
// ----------------------------------------------------------------------------
module crlf_checker #(
  parameter int unsigned BUF_DEPTH = crlf_pkg::BufDepthDef
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       operation_i,
  input logic [7:0] rx_byte_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       last_byte_o
);

  localparam int unsigned CW = $clog2(BUF_DEPTH) + 1;

  logic [CW-1:0] run_q;
  logic          out_beat;

  assign out_beat = out_valid_o && out_ready_i;

  // bytes forwarded so far in the current line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else if (out_beat) begin
      run_q <= last_byte_o ? '0 : run_q + CW'(1);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=>
      in_valid_i && $stable(operation_i) && $stable(rx_byte_i))
    else $error("input beat changed while waiting");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(out_byte_o) && $stable(last_byte_o))
    else $error("output beat changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && !last_byte_o |=> out_valid_o)
    else $error("gap inside a forwarded line");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |-> run_q < CW'(BUF_DEPTH - 1))
    else $error("forwarded line longer than the store allows");

  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid straight after reset");

endmodule

bind crlf_line_receiver crlf_checker #(
  .BUF_DEPTH(BUF_DEPTH)
) u_crlf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .operation_i (operation_i),
  .rx_byte_i   (rx_byte_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_o  (out_byte_o),
  .last_byte_o (last_byte_o)
);
